// ----- src/assert_macros.svh -----
// Assertion macros shared by the SWD bit sequencer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define SWDBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("swdbs assertion failed");

// Same-cycle implication.
`define SWDBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swdbs implication failed");

// Next-cycle implication.
`define SWDBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swdbs next-cycle implication failed");

`endif

// ----- src/swdbs_pkg.sv -----
// Package for the SWD bit sequencer: command codes, widths, control types.
// Depends on nothing; used by the interfaces, controller, datapath and top.
`timescale 1ns / 1ps

package swdbs_pkg;

  localparam int unsigned DATA_W           = 32;
  localparam int unsigned CMD_W            = 3;
  localparam int unsigned COUNT_W          = 6;
  localparam int unsigned LEVELS_W         = 33;
  localparam int unsigned RESET_CYCLES_DEF = 50;
  localparam int unsigned MAX_BITS_DEF     = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_PAR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_PAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LINE_RST  = 3'd4;

  // Line direction codes
  localparam logic DIR_OUT = 1'b0;
  localparam logic DIR_IN  = 1'b1;

  // What kind of SWCLK cycle the datapath puts into the output register
  typedef enum logic [2:0] {
    OUT_TURN  = 3'd0,
    OUT_WDATA = 3'd1,
    OUT_WPAR  = 3'd2,
    OUT_RDATA = 3'd3,
    OUT_RPAR  = 3'd4,
    OUT_LRST  = 3'd5
  } out_sel_e;

  typedef struct packed {
    logic     load;     // capture a new command word
    logic     emit;     // write one cycle into the output register
    logic     advance;  // shift data and count down
    logic     set_dir;  // update the stored line direction
    logic     dir_val;
    out_sel_e sel;
    logic     last;
  } ctl_cmd_t;

  typedef struct packed {
    logic dir;          // stored line direction
    logic cnt_zero;     // cycle counter is zero
    logic cnt_one;      // cycle counter is one
    logic in_cnt_zero;  // incoming word asks for no data bits
    logic out_free;     // output register can take a cycle now
  } dp_status_t;

endpackage

// ----- src/swdbs_if.sv -----
// Valid/ready channels of the SWD bit sequencer: command words in, cycle words out.
// Depends on swdbs_pkg.
`timescale 1ns / 1ps

interface swdbs_cmd_if
  import swdbs_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [DATA_W-1:0]   write_bits;
  logic [COUNT_W-1:0]  bit_count;
  logic [LEVELS_W-1:0] read_levels;

  modport source (output valid, command, write_bits, bit_count, read_levels,
                  input ready);
  modport sink (input valid, command, write_bits, bit_count, read_levels,
                output ready);
endinterface

interface swdbs_res_if
  import swdbs_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              swdio_level;
  logic              swdio_drive;
  logic [DATA_W-1:0] read_data;
  logic              parity_error;
  logic              last;

  modport source (output valid, swdio_level, swdio_drive, read_data, parity_error,
                  last, input ready);
  modport sink (input valid, swdio_level, swdio_drive, read_data, parity_error,
                last, output ready);
endinterface

// ----- src/swd_bit_sequencer_core.sv -----
// Top level of the SWD bit sequencer: command channel in, one word per SWCLK
// cycle out. Depends on swdbs_pkg, swdbs_if, swdbs_ctrl and swdbs_datapath.
`timescale 1ns / 1ps

// Usage
//   cmd_i carries one command word: command (write, write with parity, read,
//   read with parity, line reset), write_bits, bit_count and read_levels.
//   res_o carries one word per SWCLK cycle: swdio_level, swdio_drive,
//   read_data, parity_error and last, which marks the final cycle of a command.
// Timing
//   A command is taken only while the sequencer is idle. Its first cycle word
//   is written into the output register from the phase state that follows
//   acceptance, once the register has room; then one word follows per clock
//   while res_o is not stalled. A command's words are an optional turnaround,
//   bit_count data cycles (at most MAX_BITS) and an optional parity cycle, or
//   an optional turnaround and RESET_CYCLES cycles for a line reset.
//   The phase controller sets the rate, one SWCLK cycle per clock unless stalled.
// Reset
//   Asynchronous reset drops any pending word, returns to idle and sets the
//   line direction to host-driven.
// Stall
//   While res_o.ready is low the output register holds its word and the
//   sequencer holds its phase; no word is lost or repeated.
//   Unknown command codes are dropped without output.

module swd_bit_sequencer_core
  import swdbs_pkg::*;
#(
  parameter int unsigned RESET_CYCLES = RESET_CYCLES_DEF,
  parameter int unsigned MAX_BITS     = MAX_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  swdbs_cmd_if.sink    cmd_i,
  swdbs_res_if.source  res_o
);

  ctl_cmd_t   ctl;
  dp_status_t status;

  // Phase controller: decides which kind of SWCLK cycle comes next
  swdbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .command_i  (cmd_i.command),
    .status_i   (status),
    .in_ready_o (cmd_i.ready),
    .ctl_o      (ctl)
  );

  // Datapath: captures the word, shifts bits out, holds the output register
  swdbs_datapath #(
    .RESET_CYCLES (RESET_CYCLES),
    .MAX_BITS     (MAX_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .command_i      (cmd_i.command),
    .write_bits_i   (cmd_i.write_bits),
    .bit_count_i    (cmd_i.bit_count),
    .read_levels_i  (cmd_i.read_levels),
    .out_ready_i    (res_o.ready),
    .status_o       (status),
    .out_valid_o    (res_o.valid),
    .swdio_level_o  (res_o.swdio_level),
    .swdio_drive_o  (res_o.swdio_drive),
    .read_data_o    (res_o.read_data),
    .parity_error_o (res_o.parity_error),
    .last_o         (res_o.last)
  );

endmodule

// ----- src/swdbs_datapath.sv -----
// Datapath of the SWD bit sequencer: shift register, cycle counter, parity,
// line direction and the output register. Depends on swdbs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swdbs_datapath
  import swdbs_pkg::*;
#(
  parameter int unsigned RESET_CYCLES = RESET_CYCLES_DEF,
  parameter int unsigned MAX_BITS     = MAX_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_cmd_t            ctl_i,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [DATA_W-1:0]   write_bits_i,
  input  logic [COUNT_W-1:0]  bit_count_i,
  input  logic [LEVELS_W-1:0] read_levels_i,
  input  logic                out_ready_i,
  output dp_status_t          status_o,
  output logic                out_valid_o,
  output logic                swdio_level_o,
  output logic                swdio_drive_o,
  output logic [DATA_W-1:0]   read_data_o,
  output logic                parity_error_o,
  output logic                last_o
);

  localparam int unsigned CNT_MAX = (RESET_CYCLES > MAX_BITS) ? RESET_CYCLES : MAX_BITS;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

  logic [COUNT_W-1:0] cnt_sat;
  logic [DATA_W-1:0]  mask;
  logic [DATA_W-1:0]  rd_masked;
  logic               is_read;
  logic               par_in;

  logic [DATA_W-1:0]  shift_q;
  logic [DATA_W-1:0]  rdata_q;
  logic               par_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               dir_q;

  logic               out_valid_q, out_valid_d;
  logic               level_q, level_d;
  logic               drive_q, drive_d;
  logic [DATA_W-1:0]  data_q, data_d;
  logic               perr_q, perr_d;
  logic               last_q;

  // Saturate the count and mask off unused bits
  assign cnt_sat   = (bit_count_i > COUNT_W'(MAX_BITS)) ? COUNT_W'(MAX_BITS) : bit_count_i;
  assign mask      = (cnt_sat >= COUNT_W'(DATA_W)) ? '1
                   : ((DATA_W'(1) << cnt_sat) - DATA_W'(1));
  assign rd_masked = read_levels_i[DATA_W-1:0] & mask;
  assign is_read   = (command_i == CMD_READ) || (command_i == CMD_READ_PAR);
  assign par_in    = is_read ? ((^rd_masked) ^ read_levels_i[DATA_W])
                             : (^(write_bits_i & mask));

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.load) begin
      cnt_d = (command_i == CMD_LINE_RST) ? CNT_W'(RESET_CYCLES) : CNT_W'(cnt_sat);
    end else if (ctl_i.advance) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      shift_q <= write_bits_i;
      rdata_q <= rd_masked;
      par_q   <= par_in;
    end else if (ctl_i.advance) begin
      shift_q <= shift_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      dir_q <= DIR_OUT;
    end else begin
      cnt_q <= cnt_d;
      if (ctl_i.set_dir) begin
        dir_q <= ctl_i.dir_val;
      end
    end
  end

  // Build the cycle word for the selected kind of cycle
  always_comb begin
    level_d = 1'b0;
    drive_d = 1'b0;
    data_d  = '0;
    perr_d  = 1'b0;
    case (ctl_i.sel)
      OUT_TURN: begin
      end
      OUT_WDATA: begin
        level_d = shift_q[0];
        drive_d = 1'b1;
      end
      OUT_WPAR: begin
        level_d = par_q;
        drive_d = 1'b1;
      end
      OUT_RDATA: begin
        data_d = ctl_i.last ? rdata_q : '0;
      end
      OUT_RPAR: begin
        data_d = rdata_q;
        perr_d = par_q;
      end
      OUT_LRST: begin
        level_d = 1'b1;
        drive_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = ctl_i.emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      level_q <= level_d;
      drive_q <= drive_d;
      data_q  <= data_d;
      perr_q  <= perr_d;
      last_q  <= ctl_i.last;
    end
  end

  assign status_o.dir         = dir_q;
  assign status_o.cnt_zero    = (cnt_q == '0);
  assign status_o.cnt_one     = (cnt_q == CNT_W'(1));
  assign status_o.in_cnt_zero = (cnt_sat == '0);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign swdio_level_o  = level_q;
  assign swdio_drive_o  = drive_q;
  assign read_data_o    = data_q;
  assign parity_error_o = perr_q;
  assign last_o         = last_q;

  `SWDBS_ASSERT_IMP(a_level_needs_drive, clk_i, rst_ni, out_valid_q && !drive_q, !level_q)
  `SWDBS_ASSERT_IMP(a_data_only_on_last, clk_i, rst_ni, out_valid_q && !last_q,
                    (data_q == '0) && !perr_q)
  `SWDBS_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, ctl_i.emit, !out_valid_q || out_ready_i)

endmodule

// ----- src/swdbs_ctrl.sv -----
// Controller of the SWD bit sequencer: walks turnaround, data, parity and
// line reset phases. Depends on swdbs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swdbs_ctrl
  import swdbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] command_i,
  input  dp_status_t       status_i,
  output logic             in_ready_o,
  output ctl_cmd_t         ctl_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TURN = 5'b00010,
    ST_DATA = 5'b00100,
    ST_PAR  = 5'b01000,
    ST_LRST = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;

  function automatic logic has_parity(input logic [CMD_W-1:0] c);
    has_parity = (c == CMD_WRITE_PAR) || (c == CMD_READ_PAR);
  endfunction

  function automatic logic is_read_cmd(input logic [CMD_W-1:0] c);
    is_read_cmd = (c == CMD_READ) || (c == CMD_READ_PAR);
  endfunction

  // First phase after any turnaround; idle when no cycle remains
  function automatic state_e phase_after(input logic [CMD_W-1:0] c, input logic zero);
    state_e s;
    if (c == CMD_LINE_RST) begin
      s = ST_LRST;
    end else if (!zero) begin
      s = ST_DATA;
    end else if (has_parity(c)) begin
      s = ST_PAR;
    end else begin
      s = ST_IDLE;
    end
    return s;
  endfunction

  logic cmd_known;
  logic need_dir;

  assign cmd_known  = (command_i <= CMD_LINE_RST);
  assign need_dir   = is_read_cmd(command_i) ? DIR_IN : DIR_OUT;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ctl_o   = '{load: 1'b0, emit: 1'b0, advance: 1'b0, set_dir: 1'b0,
                dir_val: DIR_OUT, sel: OUT_TURN, last: 1'b0};
    case (state_q)
      ST_IDLE: begin
        // Drop unknown codes without a trace
        if (in_valid_i && cmd_known) begin
          ctl_o.load = 1'b1;
          cmd_d      = command_i;
          if (status_i.dir != need_dir) begin
            ctl_o.set_dir = 1'b1;
            ctl_o.dir_val = need_dir;
            state_d       = ST_TURN;
          end else begin
            state_d = phase_after(command_i, status_i.in_cnt_zero);
          end
        end
      end
      ST_TURN: begin
        if (status_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = OUT_TURN;
          state_d    = phase_after(cmd_q, status_i.cnt_zero);
          ctl_o.last = (phase_after(cmd_q, status_i.cnt_zero) == ST_IDLE);
        end
      end
      ST_DATA: begin
        if (status_i.out_free) begin
          ctl_o.emit    = 1'b1;
          ctl_o.advance = 1'b1;
          ctl_o.sel     = is_read_cmd(cmd_q) ? OUT_RDATA : OUT_WDATA;
          ctl_o.last    = status_i.cnt_one && !has_parity(cmd_q);
          if (status_i.cnt_one) begin
            state_d = has_parity(cmd_q) ? ST_PAR : ST_IDLE;
          end
        end
      end
      ST_PAR: begin
        if (status_i.out_free) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = is_read_cmd(cmd_q) ? OUT_RPAR : OUT_WPAR;
          ctl_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_LRST: begin
        if (status_i.out_free) begin
          ctl_o.emit    = 1'b1;
          ctl_o.advance = 1'b1;
          ctl_o.sel     = OUT_LRST;
          ctl_o.last    = status_i.cnt_one;
          if (status_i.cnt_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= CMD_WRITE;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
    end
  end

  `SWDBS_ASSERT_IMP(a_emit_needs_room, clk_i, rst_ni, ctl_o.emit, status_i.out_free)
  `SWDBS_ASSERT_NXT(a_last_returns_idle, clk_i, rst_ni, ctl_o.emit && ctl_o.last,
                    state_q == ST_IDLE)
  `SWDBS_ASSERT_NXT(a_turn_flips_dir, clk_i, rst_ni, ctl_o.load && ctl_o.set_dir,
                    (state_q == ST_TURN) && (status_i.dir != $past(status_i.dir)))

endmodule
